// ===== design/jcdm_pkg.sv =====
// Shared constants, register codes and width helpers for the joystick mapper.
// No dependencies; used by the interfaces, the lane and the top level.
`timescale 1ns / 1ps
package jcdm_pkg;

	localparam int DEF_SAMPLE_BITS = 10;
	localparam int CFG_IDX_BITS = 3;
	localparam logic [7:0] DZ_RESET = 8'd15;
	localparam logic [7:0] MARGIN_RESET = 8'd10;
	localparam logic [7:0] FULL_SCALE = 8'd255;
	localparam logic [7:0] MID_SCALE = 8'd128;
	localparam logic [7:0] UPPER_GAIN = 8'd127;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_THROTTLE_CAL = 3'd0,
		REG_AXIS_TWO_CAL = 3'd1,
		REG_AXIS_THREE_CAL = 3'd2,
		REG_AXIS_FOUR_CAL = 3'd3,
		REG_DEADZONE = 3'd4,
		REG_END_MARGIN = 3'd5
	} cfg_reg_t;

	// numerator magnitude bits: 8-bit gain times a (bits+1)-bit difference
	function automatic int num_bits(input int bits);
		return bits + 9;
	endfunction

	// lane stage count: clamp, segment select, gain, one stage per quotient bit, output
	function automatic int lat_of(input int bits);
		return num_bits(bits) + 4;
	endfunction

endpackage

// ===== design/jcdm_ifs.sv =====
// Valid/ready channel interfaces for sample sets and mapped values.
// Depends on jcdm_pkg for the default sample width.
`timescale 1ns / 1ps
interface jcdm_smp_if
	import jcdm_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic valid;
	logic ready;
	logic [SAMPLE_BITS-1:0] throttle_sample;
	logic [SAMPLE_BITS-1:0] axis_two_sample;
	logic [SAMPLE_BITS-1:0] axis_three_sample;
	logic [SAMPLE_BITS-1:0] axis_four_sample;

	modport source (output valid, throttle_sample, axis_two_sample, axis_three_sample,
		axis_four_sample, input ready);
	modport sink (input valid, throttle_sample, axis_two_sample, axis_three_sample,
		axis_four_sample, output ready);
endinterface

interface jcdm_res_if;
	logic valid;
	logic ready;
	logic [7:0] throttle_value;
	logic [7:0] axis_two_value;
	logic [7:0] axis_three_value;
	logic [7:0] axis_four_value;

	modport source (output valid, throttle_value, axis_two_value, axis_three_value,
		axis_four_value, input ready);
	modport sink (input valid, throttle_value, axis_two_value, axis_three_value,
		axis_four_value, output ready);
endinterface

// ===== design/jcdm_lane.sv =====
// One axis datapath: clamp, segment select, gain, pipelined restoring divider,
// floor fix, saturation and optional inversion. Depends on jcdm_pkg.
`timescale 1ns / 1ps
module jcdm_lane
	import jcdm_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter bit THROTTLE = 1'b0,
	parameter bit INVERT = 1'b0,
	parameter logic [7:0] DZ_VALUE = MID_SCALE
) (
	input logic clk,
	input logic en,
	input logic [SAMPLE_BITS-1:0] sample,
	input logic [SAMPLE_BITS-1:0] cal_min,
	input logic [SAMPLE_BITS-1:0] cal_max,
	input logic [SAMPLE_BITS-1:0] cal_ctr,
	input logic [7:0] dz,
	input logic [7:0] margin,
	output logic [7:0] value
);
	localparam int DW = SAMPLE_BITS + 2;
	localparam int DMW = SAMPLE_BITS + 1;
	localparam int NMW = num_bits(SAMPLE_BITS);
	localparam int QW = NMW + 2;

	typedef logic signed [DW-1:0] sv_t;

	typedef struct packed {
		logic force_hit;
		logic [7:0] fval;
		logic neg;
		logic [7:0] lo_y;
		logic [DMW-1:0] dmag;
	} carry_t;

	// stage 1: deadzone test and clamp
	sv_t s, mn, mx, c, top, sc, dzx, mgx;
	logic upper, f1;
	logic [7:0] fv1;

	always_comb begin
		s = sv_t'({2'b00, sample});
		mn = sv_t'({2'b00, cal_min});
		mx = sv_t'({2'b00, cal_max});
		c = sv_t'({2'b00, cal_ctr});
		dzx = sv_t'({{(DW-8){1'b0}}, dz});
		mgx = sv_t'({{(DW-8){1'b0}}, margin});
		upper = 1'b0;
		if (THROTTLE) begin
			top = mx - dzx;
			sc = s;
			f1 = (s >= top);
			fv1 = FULL_SCALE;
		end else begin
			top = mx - mgx;
			sc = (s > top) ? top : s;
			if (sc < mn)
				sc = mn;
			upper = (sc > c);
			f1 = (s <= c + dzx) && (s >= c - dzx);
			fv1 = DZ_VALUE;
		end
	end

	sv_t sc_s1, top_s1;
	logic upper_s1, force_s1;
	logic [7:0] fval_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s1 <= sc;
			top_s1 <= top;
			upper_s1 <= upper;
			force_s1 <= f1;
			fval_s1 <= fv1;
		end
	end

	// stage 2: pick the segment, form difference and span
	sv_t lo_x, hi_x, nd, sp;
	logic [7:0] k, lo_y, hi_y, fv2;
	logic f2;

	always_comb begin
		if (THROTTLE) begin
			lo_x = mn;
			hi_x = top_s1;
			k = FULL_SCALE;
			lo_y = 8'd0;
			hi_y = FULL_SCALE;
		end else if (upper_s1) begin
			lo_x = c;
			hi_x = top_s1;
			k = UPPER_GAIN;
			lo_y = MID_SCALE;
			hi_y = FULL_SCALE;
		end else begin
			lo_x = mn;
			hi_x = c;
			k = MID_SCALE;
			lo_y = 8'd0;
			hi_y = MID_SCALE;
		end
		nd = sc_s1 - lo_x;
		sp = hi_x - lo_x;
		f2 = force_s1;
		fv2 = fval_s1;
		// zero span gives the segment's upper end
		if (!force_s1 && sp == '0) begin
			f2 = 1'b1;
			fv2 = hi_y;
		end
	end

	sv_t nd_s2, sp_s2;
	logic [7:0] k_s2, lo_y_s2, fval_s2;
	logic force_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			nd_s2 <= nd;
			sp_s2 <= sp;
			k_s2 <= k;
			lo_y_s2 <= lo_y;
			force_s2 <= f2;
			fval_s2 <= fv2;
		end
	end

	// stage 3: magnitudes and gain
	sv_t nd_abs, sp_abs;
	logic [NMW-1:0] num;
	carry_t c3;

	always_comb begin
		nd_abs = nd_s2[DW-1] ? -nd_s2 : nd_s2;
		sp_abs = sp_s2[DW-1] ? -sp_s2 : sp_s2;
		num = NMW'(k_s2 * nd_abs[DMW-1:0]);
		c3.force_hit = force_s2;
		c3.fval = fval_s2;
		c3.neg = nd_s2[DW-1] ^ sp_s2[DW-1];
		c3.lo_y = lo_y_s2;
		c3.dmag = sp_abs[DMW-1:0];
	end

	carry_t carry_sd [NMW+1];
	logic [DMW-1:0] rem_sd [NMW+1];
	logic [NMW-1:0] nq_sd [NMW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			carry_sd[0] <= c3;
			rem_sd[0] <= '0;
			nq_sd[0] <= num;
		end
	end

	// one quotient bit per stage
	for (genvar i = 0; i < NMW; i++) begin : g_div
		logic [DMW:0] t, d;
		logic ge;
		logic [DMW:0] diff;

		always_comb begin
			t = {rem_sd[i], nq_sd[i][NMW-1]};
			d = {1'b0, carry_sd[i].dmag};
			ge = (t >= d);
			diff = ge ? (t - d) : t;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				carry_sd[i+1] <= carry_sd[i];
				rem_sd[i+1] <= diff[DMW-1:0];
				nq_sd[i+1] <= {nq_sd[i][NMW-2:0], ge};
			end
		end
	end

	// floor correction, offset, saturation
	logic signed [QW-1:0] qs, r;
	logic [7:0] v;

	always_comb begin
		qs = $signed({2'b00, nq_sd[NMW]});
		if (carry_sd[NMW].neg)
			qs = -(qs + QW'(rem_sd[NMW] != '0));
		r = qs + $signed({{(QW-8){1'b0}}, carry_sd[NMW].lo_y});
		if (r < 0)
			v = 8'd0;
		else if (r > $signed(QW'(FULL_SCALE)))
			v = FULL_SCALE;
		else
			v = r[7:0];
		if (carry_sd[NMW].force_hit)
			v = carry_sd[NMW].fval;
		if (INVERT)
			v = ~v;
	end

	logic [7:0] value_s4;

	always_ff @(posedge clk) begin
		if (en)
			value_s4 <= v;
	end

	assign value = value_s4;

endmodule

// ===== design/joystick_calibrated_deadzone_mapper.sv =====
// Joystick deadzone and calibration mapper, top level.
// Depends on jcdm_pkg, jcdm_ifs and jcdm_lane.
//
// Usage:
//  smp carries one word of four raw samples; res returns one word of four
//  8-bit values for each sample word, in order. Both are valid/ready.
//  Calibration, deadzone width and end margin are written through cfg_we,
//  cfg_index and cfg_data while no word is in flight.
//  From acceptance to res.valid a word passes two clamp/select stages,
//  a gain stage, one restoring-divider stage per quotient bit, and the
//  output register.
//  Throughput: one word per cycle while res is not stalled; every stage of
//  the divider holds its own word.
//  When res is stalled with a word waiting, the whole pipeline holds and
//  smp.ready drops; nothing is lost or repeated.
//  Reset clears the valid bits and loads the default calibration
//  (full range, centre at mid scale, deadzone 15, margin 10).
`timescale 1ns / 1ps
module joystick_calibrated_deadzone_mapper
	import jcdm_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input logic clk,
	input logic arst_n,
	jcdm_smp_if.sink smp,
	jcdm_res_if.source res,
	input logic cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [3*SAMPLE_BITS-1:0] cfg_data
);
	localparam int B = SAMPLE_BITS;
	localparam int LAT = lat_of(SAMPLE_BITS);
	localparam logic [B-1:0] ALL_ONES = {B{1'b1}};
	localparam logic [B-1:0] MID = B'(1) << (B - 1);
	localparam logic [3*B-1:0] AXIS_RESET = {MID, ALL_ONES, B'(0)};

	logic [2*B-1:0] thr_cal_q;
	logic [3*B-1:0] ax2_cal_q, ax3_cal_q, ax4_cal_q;
	logic [7:0] dz_q, margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_cal_q <= {ALL_ONES, B'(0)};
			ax2_cal_q <= AXIS_RESET;
			ax3_cal_q <= AXIS_RESET;
			ax4_cal_q <= AXIS_RESET;
			dz_q <= DZ_RESET;
			margin_q <= MARGIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THROTTLE_CAL: thr_cal_q <= cfg_data[2*B-1:0];
				REG_AXIS_TWO_CAL: ax2_cal_q <= cfg_data;
				REG_AXIS_THREE_CAL: ax3_cal_q <= cfg_data;
				REG_AXIS_FOUR_CAL: ax4_cal_q <= cfg_data;
				REG_DEADZONE: dz_q <= cfg_data[7:0];
				REG_END_MARGIN: margin_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves when the output register is free or being taken
	logic adv;
	logic [LAT-1:0] vld_q;

	assign adv = !vld_q[LAT-1] || res.ready;
	assign smp.ready = adv;
	assign res.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[LAT-2:0], smp.valid};
	end

	jcdm_lane #(
		.SAMPLE_BITS(SAMPLE_BITS), .THROTTLE(1'b1), .INVERT(1'b1), .DZ_VALUE(FULL_SCALE)
	) u_thr (
		.clk(clk), .en(adv), .sample(smp.throttle_sample),
		.cal_min(thr_cal_q[B-1:0]), .cal_max(thr_cal_q[2*B-1:B]), .cal_ctr(B'(0)),
		.dz(dz_q), .margin(margin_q), .value(res.throttle_value)
	);

	jcdm_lane #(
		.SAMPLE_BITS(SAMPLE_BITS), .THROTTLE(1'b0), .INVERT(1'b1), .DZ_VALUE(UPPER_GAIN)
	) u_ax2 (
		.clk(clk), .en(adv), .sample(smp.axis_two_sample),
		.cal_min(ax2_cal_q[B-1:0]), .cal_max(ax2_cal_q[2*B-1:B]),
		.cal_ctr(ax2_cal_q[3*B-1:2*B]),
		.dz(dz_q), .margin(margin_q), .value(res.axis_two_value)
	);

	jcdm_lane #(
		.SAMPLE_BITS(SAMPLE_BITS), .THROTTLE(1'b0), .INVERT(1'b0), .DZ_VALUE(MID_SCALE)
	) u_ax3 (
		.clk(clk), .en(adv), .sample(smp.axis_three_sample),
		.cal_min(ax3_cal_q[B-1:0]), .cal_max(ax3_cal_q[2*B-1:B]),
		.cal_ctr(ax3_cal_q[3*B-1:2*B]),
		.dz(dz_q), .margin(margin_q), .value(res.axis_three_value)
	);

	jcdm_lane #(
		.SAMPLE_BITS(SAMPLE_BITS), .THROTTLE(1'b0), .INVERT(1'b0), .DZ_VALUE(MID_SCALE)
	) u_ax4 (
		.clk(clk), .en(adv), .sample(smp.axis_four_sample),
		.cal_min(ax4_cal_q[B-1:0]), .cal_max(ax4_cal_q[2*B-1:B]),
		.cal_ctr(ax4_cal_q[3*B-1:2*B]),
		.dz(dz_q), .margin(margin_q), .value(res.axis_four_value)
	);

endmodule
